// ===== rtl/sorted_unique_list_table_defines.svh =====
// Assertion macros used by the sorted list table top level
`ifndef SORTED_UNIQUE_LIST_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_LIST_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define SULT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define SULT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
// antecedent implies consequent on the next edge
`define SULT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SULT_ASSERT(lbl, prop, msg)
`define SULT_NEVER(lbl, expr, msg)
`define SULT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/sult_pkg.sv =====
// Types and constants of the sorted list table
`default_nettype none
package sult_pkg;

	localparam int CAPACITY = 64;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 6;
	localparam int ENTRY_W  = 7;
	// count holds 0..CAPACITY
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_BADPOS    = 3'd3,
		ST_NOTFOUND  = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef struct packed {
		op_t                      operation;
		logic signed [VAL_W-1:0]  value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [VAL_W-1:0]  read_value;
		logic [POS_W-1:0]         found_position;
		logic [ENTRY_W-1:0]       entry_count;
	} rsp_t;

	// per-cell load selection
	typedef struct packed {
		logic load_new;
		logic take_prev;
		logic take_next;
	} cell_cmd_t;

	// per-cell compare against the beat's value
	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flags_t;

endpackage
`default_nettype wire

// ===== rtl/sult_cell.sv =====
// One storage cell of the sorted chain: holds an entry and compares it to the key
`default_nettype none
module sult_cell (
	input  wire logic                                  clk,
	input  wire sult_pkg::cell_cmd_t                   cmd,
	input  wire logic signed [sult_pkg::VAL_W-1:0]     key,
	input  wire logic signed [sult_pkg::VAL_W-1:0]     prev_value,
	input  wire logic signed [sult_pkg::VAL_W-1:0]     next_value,
	output logic signed [sult_pkg::VAL_W-1:0]          value,
	output sult_pkg::cell_flags_t                      flags
);

	logic signed [sult_pkg::VAL_W-1:0] value_q;

	// load new key, shift up from lower neighbor, or shift down from upper one
	always_ff @(posedge clk) begin
		if (cmd.load_new) begin
			value_q <= key;
		end else if (cmd.take_prev) begin
			value_q <= prev_value;
		end else if (cmd.take_next) begin
			value_q <= next_value;
		end
	end

	// signed compare against the key
	always_comb begin
		flags.lt = (value_q < key);
		flags.eq = (value_q == key);
	end

	assign value = value_q;

endmodule
`default_nettype wire

// ===== rtl/sorted_unique_list_table.sv =====
// Sorted unique list table: top level with cell chain, result logic and output register
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------
//   request | req_valid | req_stall | req (sult_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp (sult_pkg::rsp_t)
//
// Every operation completes in the cycle its beat is accepted: all cells compare
// against the value at once and shift one place together.
// One beat per cycle is sustained while rsp_stall is low; the result appears in the output register
// on the next cycle.
// Reset clears the entry count and the output valid; cell contents stay undefined.
// req_stall is high only while a result is held and rsp_stall is high.
`default_nettype none
`include "sorted_unique_list_table_defines.svh"
module sorted_unique_list_table (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire sult_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output sult_pkg::rsp_t     rsp
);

	localparam int CAP   = sult_pkg::CAPACITY;
	localparam int CNT_W = sult_pkg::CNT_W;
	localparam int CMP_W = sult_pkg::CMP_W;
	localparam int POS_W = sult_pkg::POS_W;
	localparam int VAL_W = sult_pkg::VAL_W;

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_nxt;
	logic                      rsp_valid_q;
	sult_pkg::rsp_t            rsp_q;
	sult_pkg::rsp_t            rsp_nxt;

	logic                      accept;
	logic                      empty;
	logic                      full;
	logic                      pos_bad;
	logic                      dup;
	logic                      ins;
	logic                      rem;
	logic [CMP_W-1:0]          pos_ext;
	logic [CMP_W-1:0]          cnt_ext;

	logic signed [VAL_W-1:0]   cell_val [CAP];
	sult_pkg::cell_flags_t     cell_flg [CAP];
	logic [CAP-1:0]            valid_v;
	logic [CAP-1:0]            lt_v;
	logic [CAP-1:0]            ge_v;
	logic [CAP-1:0]            hit_v;
	logic [CAP-1:0]            sel_rd;
	logic [CAP-1:0]            at_or_above_pos;

	logic signed [VAL_W-1:0]   rd_or;
	logic [POS_W-1:0]          fp_or;
	logic                      order_ok;

	// handshake: one result register parts the two sides
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	// table status
	assign pos_ext = CMP_W'(req.position);
	assign cnt_ext = CMP_W'(count_q);
	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(CAP));
	assign pos_bad = (pos_ext >= cnt_ext);
	assign dup     = |hit_v;
	assign ins     = accept && (req.operation == sult_pkg::OP_INSERT) && !dup && !full;
	assign rem     = accept && (req.operation == sult_pkg::OP_REMOVE) && !empty && !pos_bad;

	// cell chain
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		localparam int PREV = (i == 0) ? 0 : i - 1;
		localparam int NEXT = (i == CAP - 1) ? i : i + 1;
		sult_pkg::cell_cmd_t cmd;
		logic                prev_lt;
		logic                prev_ge;

		assign valid_v[i]         = (CNT_W'(i) < count_q);
		assign lt_v[i]            = valid_v[i] && cell_flg[i].lt;
		assign ge_v[i]            = valid_v[i] && !cell_flg[i].lt;
		assign hit_v[i]           = valid_v[i] && cell_flg[i].eq;
		assign at_or_above_pos[i] = (CMP_W'(i) >= pos_ext);
		assign sel_rd[i]          = valid_v[i] && (CMP_W'(i) == pos_ext);
		assign prev_lt            = (i == 0) ? 1'b1 : lt_v[PREV];
		assign prev_ge            = (i == 0) ? 1'b0 : ge_v[PREV];

		// insert: new value after the last smaller entry, larger ones move up; remove: higher ones move down
		always_comb begin
			cmd.load_new  = ins && prev_lt && !lt_v[i];
			cmd.take_prev = ins && prev_ge;
			cmd.take_next = rem && at_or_above_pos[i] && (i != CAP - 1);
		end

		sult_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.key        (req.value),
			.prev_value (cell_val[PREV]),
			.next_value (cell_val[NEXT]),
			.value      (cell_val[i]),
			.flags      (cell_flg[i])
		);
	end

	// read mux and match encoder as OR trees: at most one cell selects
	always_comb begin
		rd_or = '0;
		fp_or = '0;
		for (int k = 0; k < CAP; k++) begin
			if (sel_rd[k]) begin
				rd_or = rd_or | cell_val[k];
			end
			if (hit_v[k]) begin
				fp_or = fp_or | POS_W'(k);
			end
		end
	end

	// result and next count
	always_comb begin
		count_nxt              = count_q;
		rsp_nxt.status         = sult_pkg::ST_OK;
		rsp_nxt.read_value     = '0;
		rsp_nxt.found_position = '0;
		case (req.operation)
			sult_pkg::OP_INSERT: begin
				if (dup) begin
					rsp_nxt.status = sult_pkg::ST_DUPLICATE;
				end else if (full) begin
					rsp_nxt.status = sult_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			sult_pkg::OP_REMOVE: begin
				if (empty) begin
					rsp_nxt.status = sult_pkg::ST_EMPTY;
				end else if (pos_bad) begin
					rsp_nxt.status = sult_pkg::ST_BADPOS;
				end else begin
					count_nxt = count_q - 1'b1;
				end
			end
			sult_pkg::OP_READ: begin
				if (empty) begin
					rsp_nxt.status = sult_pkg::ST_EMPTY;
				end else if (pos_bad) begin
					rsp_nxt.status = sult_pkg::ST_BADPOS;
				end else begin
					rsp_nxt.read_value = rd_or;
				end
			end
			sult_pkg::OP_SEARCH: begin
				if (empty) begin
					rsp_nxt.status = sult_pkg::ST_EMPTY;
				end else if (dup) begin
					rsp_nxt.found_position = fp_or;
				end else begin
					rsp_nxt.status = sult_pkg::ST_NOTFOUND;
				end
			end
			default: begin
				rsp_nxt.status = sult_pkg::ST_OK;
			end
		endcase
		rsp_nxt.entry_count = sult_pkg::ENTRY_W'(count_nxt);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// held entries stay strictly ascending
	always_comb begin
		order_ok = 1'b1;
		for (int k = 1; k < CAP; k++) begin
			if (valid_v[k] && !(cell_val[k-1] < cell_val[k])) begin
				order_ok = 1'b0;
			end
		end
	end

	`SULT_ASSERT(a_count_range, count_q <= CNT_W'(CAP), "entry count above capacity")
	`SULT_NEVER(a_order, !order_ok, "entries out of ascending order")
	`SULT_NEXT(a_ins_count, ins, count_q == CNT_W'($past(count_q) + 1'b1), "insert count")
	`SULT_NEXT(a_rem_count, rem, count_q == CNT_W'($past(count_q) - 1'b1), "remove count")
	`SULT_NEXT(a_rsp_after_accept, accept, rsp_valid_q, "accepted beat left no result")

endmodule
`default_nettype wire
